FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off during reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising edge, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sbba_pkg.sv
// ----------------------------------------------------------------------------
// sbba_pkg
// Types, widths and helpers for the spectral bilinear bin accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package sbba_pkg;

    localparam int BINS_DEFAULT = 1024;
    localparam int BIN_W        = 10;
    localparam int VAL_W        = 24;
    localparam int PROD_W       = 2 * VAL_W;
    localparam int DELTA_W      = PROD_W + 2;
    localparam int SUM_W        = 64;
    localparam int ROW_W        = 4 * SUM_W;

    typedef enum logic {
        OP_ACC  = 1'b0,
        OP_READ = 1'b1
    } t_op;

    typedef struct packed {
        t_op                      op;
        logic [BIN_W-1:0]         bin;
        logic                     descending;
        logic signed [VAL_W-1:0]  bra_re;
        logic signed [VAL_W-1:0]  bra_im;
        logic signed [VAL_W-1:0]  ket_re;
        logic signed [VAL_W-1:0]  ket_im;
        logic signed [VAL_W-1:0]  dbra_re;
        logic signed [VAL_W-1:0]  dbra_im;
        logic signed [VAL_W-1:0]  dket_re;
        logic signed [VAL_W-1:0]  dket_im;
    } t_in_item;

    typedef struct packed {
        logic [BIN_W-1:0]         out_bin;
        logic signed [SUM_W-1:0]  p_re;
        logic signed [SUM_W-1:0]  p_im;
        logic signed [SUM_W-1:0]  w_re;
        logic signed [SUM_W-1:0]  w_im;
    } t_out_item;

    // One RAM row: the four sums of a bin.
    typedef struct packed {
        logic signed [SUM_W-1:0]  p_re;
        logic signed [SUM_W-1:0]  p_im;
        logic signed [SUM_W-1:0]  w_re;
        logic signed [SUM_W-1:0]  w_im;
    } t_sums;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Signed add with clamp to the 64-bit limits.
    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0]   acc,
        input logic signed [DELTA_W-1:0] delta
    );
        logic signed [SUM_W:0] s;
        s = (SUM_W+1)'(acc) + (SUM_W+1)'(delta);
        if (s[SUM_W] != s[SUM_W-1]) begin
            return s[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        return s[SUM_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/sbba_ram.sv
// ----------------------------------------------------------------------------
// sbba_ram
// Simple dual-port RAM: one write port, one read port, registered read,
// read-first on a same-address collision.
// ----------------------------------------------------------------------------
`default_nettype none

module sbba_ram
    import sbba_pkg::*;
#(
    parameter  int WIDTH = ROW_W,
    parameter  int DEPTH = BINS_DEFAULT,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/spectral_bilinear_bin_accumulator.sv
// ----------------------------------------------------------------------------
// spectral_bilinear_bin_accumulator
// Per-bin saturating accumulator of bilinear complex terms p and w.
// ----------------------------------------------------------------------------
// Takes one transaction per cycle unless stalled. An accumulate transaction
// forms p = Re(b)k + conj(b)Re(k) and w = conj(db)Re(k) - Re(b)dk from the
// Q8.15 inputs (conjugated when descending is 0) and adds them, saturating
// at 64 bits, to the Q33.30 sums of its bin; a bin at or beyond BINS is
// dropped. A read transaction returns the bin's four sums and zeroes them
// (zeros for a bin beyond BINS). Results pass the stage 1, 2, 3 and output
// registers. The sums live in one RAM row per bin with one write and one
// read port; the read-modify-write spans the last two stages and one bypass
// register covers back-to-back hits on the same bin: one transaction per
// cycle whatever the bin order, save a read stalled for the output register.
// After reset a clearing pass writes zero to every row, one row per cycle;
// o_in_ready stays low until it is done. The output register lets accumulate
// traffic keep flowing while a read result waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module spectral_bilinear_bin_accumulator
    import sbba_pkg::*;
#(
    parameter int BINS = BINS_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    localparam int            AW       = $clog2(BINS);
    localparam logic [AW-1:0] LAST_ROW = AW'(BINS - 1);

    // ------------------------------------------------------------------
    // Handshake / stage advance
    // ------------------------------------------------------------------
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_out_valid;
    logic r_clearing;
    logic [AW-1:0] r_clr_addr;

    t_op  r_s3_op;
    logic r_s3_ok;

    logic out_free, s3_go, s3_free, s2_free, s1_free, in_take;
    logic out_load, commit_we;

    assign out_free   = !r_out_valid || i_out_ready;
    // Accumulates retire without the output register; reads need it free.
    assign s3_go      = r_s3_valid && (r_s3_op == OP_ACC || out_free);
    assign s3_free    = !r_s3_valid || s3_go;
    assign s2_free    = !r_s2_valid || s3_free;
    assign s1_free    = !r_s1_valid || s2_free;
    assign o_in_ready = s1_free && !r_clearing;
    assign in_take    = i_in_valid && o_in_ready;

    assign out_load   = s3_go && r_s3_op == OP_READ;
    assign commit_we  = s3_go && r_s3_ok;

    // ------------------------------------------------------------------
    // Stage 1: captured transaction and bin range check
    // ------------------------------------------------------------------
    t_in_item r_s1_item;
    logic     r_s1_ok;
    logic     n_s1_ok;

    assign n_s1_ok = int'(i_in.bin) < BINS;

    always_ff @(posedge i_clk) begin
        if (s1_free) begin
            r_s1_item <= i_in;
            r_s1_ok   <= n_s1_ok;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the seven 24x24 products
    // ------------------------------------------------------------------
    t_op                     r_s2_op;
    logic [BIN_W-1:0]        r_s2_bin;
    logic                    r_s2_ok;
    logic                    r_s2_desc;
    logic signed [PROD_W-1:0] r_s2_br_kr, r_s2_br_ki, r_s2_bi_kr;
    logic signed [PROD_W-1:0] r_s2_dbr_kr, r_s2_br_dkr, r_s2_dbi_kr, r_s2_br_dki;
    logic signed [PROD_W-1:0] n_s2_br_kr, n_s2_br_ki, n_s2_bi_kr;
    logic signed [PROD_W-1:0] n_s2_dbr_kr, n_s2_br_dkr, n_s2_dbi_kr, n_s2_br_dki;

    assign n_s2_br_kr  = r_s1_item.bra_re  * r_s1_item.ket_re;
    assign n_s2_br_ki  = r_s1_item.bra_re  * r_s1_item.ket_im;
    assign n_s2_bi_kr  = r_s1_item.bra_im  * r_s1_item.ket_re;
    assign n_s2_dbr_kr = r_s1_item.dbra_re * r_s1_item.ket_re;
    assign n_s2_br_dkr = r_s1_item.bra_re  * r_s1_item.dket_re;
    assign n_s2_dbi_kr = r_s1_item.dbra_im * r_s1_item.ket_re;
    assign n_s2_br_dki = r_s1_item.bra_re  * r_s1_item.dket_im;

    always_ff @(posedge i_clk) begin
        if (s2_free) begin
            r_s2_op     <= r_s1_item.op;
            r_s2_bin    <= r_s1_item.bin;
            r_s2_ok     <= r_s1_ok;
            r_s2_desc   <= r_s1_item.descending;
            r_s2_br_kr  <= n_s2_br_kr;
            r_s2_br_ki  <= n_s2_br_ki;
            r_s2_bi_kr  <= n_s2_bi_kr;
            r_s2_dbr_kr <= n_s2_dbr_kr;
            r_s2_br_dkr <= n_s2_br_dkr;
            r_s2_dbi_kr <= n_s2_dbi_kr;
            r_s2_br_dki <= n_s2_br_dki;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: combined terms; RAM row read issued as the item enters
    // ------------------------------------------------------------------
    logic [BIN_W-1:0]          r_s3_bin;
    logic signed [DELTA_W-1:0] r_s3_dp_re, r_s3_dp_im, r_s3_dw_re, r_s3_dw_im;
    logic signed [DELTA_W-1:0] n_s3_dp_re, n_s3_dp_im, n_s3_dw_re, n_s3_dw_im;

    always_comb begin
        n_s3_dp_re = DELTA_W'(r_s2_br_kr) + DELTA_W'(r_s2_br_kr);
        n_s3_dw_re = DELTA_W'(r_s2_dbr_kr) - DELTA_W'(r_s2_br_dkr);
        // Imaginary parts flip sign when energy is not descending.
        if (r_s2_desc) begin
            n_s3_dp_im = DELTA_W'(r_s2_br_ki) - DELTA_W'(r_s2_bi_kr);
            n_s3_dw_im = -DELTA_W'(r_s2_dbi_kr) - DELTA_W'(r_s2_br_dki);
        end else begin
            n_s3_dp_im = DELTA_W'(r_s2_bi_kr) - DELTA_W'(r_s2_br_ki);
            n_s3_dw_im = DELTA_W'(r_s2_dbi_kr) + DELTA_W'(r_s2_br_dki);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_free) begin
            r_s3_op    <= r_s2_op;
            r_s3_bin   <= r_s2_bin;
            r_s3_ok    <= r_s2_ok;
            r_s3_dp_re <= n_s3_dp_re;
            r_s3_dp_im <= n_s3_dp_im;
            r_s3_dw_re <= n_s3_dw_re;
            r_s3_dw_im <= n_s3_dw_im;
        end
    end

    // ------------------------------------------------------------------
    // Sum RAM and bypass
    // ------------------------------------------------------------------
    logic [AW-1:0]    s3_addr;
    logic [ROW_W-1:0] ram_rdata;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [ROW_W-1:0] ram_wdata;

    // The row written at the edge where the stage 3 read was issued; the
    // RAM returns the old contents in that case.
    logic          r_fwd_valid;
    logic [AW-1:0] r_fwd_addr;
    t_sums         r_fwd_data;

    t_sums old_sums, new_sums, commit_data;
    t_out_item n_out;

    assign s3_addr = AW'(r_s3_bin);

    always_comb begin
        if (r_fwd_valid && r_fwd_addr == s3_addr) begin
            old_sums = r_fwd_data;
        end else begin
            old_sums = t_sums'(ram_rdata);
        end
        new_sums.p_re = sat_add(old_sums.p_re, r_s3_dp_re);
        new_sums.p_im = sat_add(old_sums.p_im, r_s3_dp_im);
        new_sums.w_re = sat_add(old_sums.w_re, r_s3_dw_re);
        new_sums.w_im = sat_add(old_sums.w_im, r_s3_dw_im);
        // A read clears the row.
        commit_data = (r_s3_op == OP_READ) ? '0 : new_sums;

        n_out.out_bin = r_s3_bin;
        n_out.p_re    = r_s3_ok ? old_sums.p_re : '0;
        n_out.p_im    = r_s3_ok ? old_sums.p_im : '0;
        n_out.w_re    = r_s3_ok ? old_sums.w_re : '0;
        n_out.w_im    = r_s3_ok ? old_sums.w_im : '0;
    end

    // Clearing pass owns the write port until it finishes.
    assign ram_we    = r_clearing || commit_we;
    assign ram_waddr = r_clearing ? r_clr_addr : s3_addr;
    assign ram_wdata = r_clearing ? '0 : ROW_W'(commit_data);

    sbba_ram #(
        .WIDTH (ROW_W),
        .DEPTH (BINS)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (s3_free),
        .i_raddr (AW'(r_s2_bin)),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (s3_free) begin
            r_fwd_addr <= s3_addr;
            r_fwd_data <= commit_data;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= in_take;
            end
            if (s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s3_free) begin
                r_s3_valid  <= r_s2_valid;
                r_fwd_valid <= commit_we;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_clearing) begin
                if (r_clr_addr == LAST_ROW) begin
                    r_clearing <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_IMP(a_clr_pipe_empty, i_clk, i_rst_n, r_clearing, !(r_s1_valid || r_s2_valid || r_s3_valid), "pipeline busy during clearing pass")
    `ASSERT_IMP(a_clr_no_ready, i_clk, i_rst_n, r_clearing, !o_in_ready, "input ready during clearing pass")
    `ASSERT_IMP(a_read_needs_slot, i_clk, i_rst_n, out_load, out_free, "read result loaded over a pending result")
    `ASSERT_NEXT(a_fwd_capture, i_clk, i_rst_n, s3_free && commit_we, r_fwd_valid, "bypass missed a row write")

endmodule

`default_nettype wire

FILE: tb/sbba_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sbba_result_checker
// Watches both channels of the bin accumulator, keeps its own copy of the
// per-bin sums and checks every read result against the predicted one.
// ----------------------------------------------------------------------------
module sbba_result_checker
    import sbba_pkg::*;
#(
    parameter int BINS = BINS_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_acc_count,
    output int        o_read_count,
    output int        o_sat_count
);

    t_sums     bin_sums [BINS];
    t_out_item pending_reads [$];
    t_out_item want;

    function automatic logic signed [SUM_W-1:0] clamp_add(
        input logic signed [SUM_W-1:0] acc,
        input longint                  delta
    );
        if (delta > 0 && acc > SUM_MAX - delta) return SUM_MAX;
        if (delta < 0 && acc < SUM_MIN - delta) return SUM_MIN;
        return acc + delta;
    endfunction

    // Form p and w of one accumulate transaction and fold them into its bin.
    task automatic add_terms(input t_in_item it);
        longint br, bi, kr, ki, dbr, dbi, dkr, dki;
        longint p_re_term, p_im_term, w_re_term, w_im_term;
        if (it.bin >= BINS) return;
        br  = signed'(it.bra_re);
        bi  = signed'(it.bra_im);
        kr  = signed'(it.ket_re);
        ki  = signed'(it.ket_im);
        dbr = signed'(it.dbra_re);
        dbi = signed'(it.dbra_im);
        dkr = signed'(it.dket_re);
        dki = signed'(it.dket_im);
        p_re_term = 2 * (br * kr);
        p_im_term = br * ki - bi * kr;
        w_re_term = dbr * kr - br * dkr;
        w_im_term = -(dbi * kr) - br * dki;
        // rising or flat energy: conjugate both terms
        if (!it.descending) begin
            p_im_term = -p_im_term;
            w_im_term = -w_im_term;
        end
        bin_sums[it.bin].p_re = clamp_add(bin_sums[it.bin].p_re, p_re_term);
        bin_sums[it.bin].p_im = clamp_add(bin_sums[it.bin].p_im, p_im_term);
        bin_sums[it.bin].w_re = clamp_add(bin_sums[it.bin].w_re, w_re_term);
        bin_sums[it.bin].w_im = clamp_add(bin_sums[it.bin].w_im, w_im_term);
    endtask

    // Read-and-clear; an out-of-range bin reads as zero.
    task automatic take_bin(input t_in_item it);
        t_out_item res;
        res         = '0;
        res.out_bin = it.bin;
        if (it.bin < BINS) begin
            res.p_re          = bin_sums[it.bin].p_re;
            res.p_im          = bin_sums[it.bin].p_im;
            res.w_re          = bin_sums[it.bin].w_re;
            res.w_im          = bin_sums[it.bin].w_im;
            bin_sums[it.bin] = '0;
        end
        pending_reads.push_back(res);
    endtask

    task automatic check_field(
        input string                   name,
        input logic signed [SUM_W-1:0] want_v,
        input logic signed [SUM_W-1:0] got_v
    );
        if (got_v !== want_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
            o_fail_count++;
        end
    endtask

    function automatic bit is_clamped(input logic signed [SUM_W-1:0] v);
        return v == SUM_MAX || v == SUM_MIN;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (bin_sums[b]) bin_sums[b] = '0;
            pending_reads.delete();
            o_fail_count = 0;
            o_acc_count  = 0;
            o_read_count = 0;
            o_sat_count  = 0;
        end else begin
            // results first, so a result can never match its own transaction
            if (i_out_valid && i_out_ready) begin
                if (pending_reads.size() == 0) begin
                    $error("unexpected result for bin %0d", i_out.out_bin);
                    o_fail_count++;
                end else begin
                    want = pending_reads.pop_front();
                    check_field("out_bin", want.out_bin, i_out.out_bin);
                    check_field("p_re", want.p_re, i_out.p_re);
                    check_field("p_im", want.p_im, i_out.p_im);
                    check_field("w_re", want.w_re, i_out.w_re);
                    check_field("w_im", want.w_im, i_out.w_im);
                    if (is_clamped(want.p_re) || is_clamped(want.p_im) ||
                        is_clamped(want.w_re) || is_clamped(want.w_im)) begin
                        o_sat_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in.op == OP_READ) begin
                    take_bin(i_in);
                    o_read_count++;
                end else begin
                    add_terms(i_in);
                    o_acc_count++;
                end
            end
        end
        o_pending = pending_reads.size();
    end

endmodule

FILE: tb/tb_spectral_bilinear_bin_accumulator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_spectral_bilinear_bin_accumulator
// Drives accumulate and read transactions into the bin accumulator, with
// random idling on both channels, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
// Phases: a directed opening (extreme values, both conjugation senses,
// back-to-back hits on one bin, read right after accumulate and vice versa),
// random bursts on small sets of hot bins mixed with noise, a long output
// hold-off that backs the block up, a full drain, a stretch at full rate on
// both sides, and a closing run of extreme-value hits on two bins that grows
// their sums toward the limits from both sides.
// ----------------------------------------------------------------------------
module tb_spectral_bilinear_bin_accumulator;
    import sbba_pkg::*;

    localparam int BINS         = BINS_DEFAULT;
    localparam int RESET_CYCLES = 6;
    localparam int IDLE_PCT     = 26;     // idle share of each side, percent
    localparam int HOLD_CYCLES  = 400;    // long output hold-off
    localparam int HOLD_READS   = 32;     // reads offered during the hold-off
    localparam int DRAIN_CYCLES = 10;     // pipeline is 3 deep, plus margin
    // extreme hits per bin in the closing run
    localparam int SAT_HITS     = 12;
    localparam int LIMIT_NS     = 2_000_000;

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    // receiver behavior, owned by the stimulus process
    typedef enum logic [1:0] {
        RX_RANDOM,
        RX_STEADY,
        RX_HOLD
    } t_rx_mode;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out;

    int        fail_count;
    int        reads_outstanding;
    int        acc_count;
    int        read_count;
    int        sat_results;

    bit        gaps_on = 1'b1;
    t_rx_mode  rx_mode = RX_RANDOM;
    int        held_cycles = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    spectral_bilinear_bin_accumulator #(
        .BINS (BINS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    sbba_result_checker #(
        .BINS (BINS)
    ) result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in         (i_in),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out        (o_out),
        .o_fail_count (fail_count),
        .o_pending    (reads_outstanding),
        .o_acc_count  (acc_count),
        .o_read_count (read_count),
        .o_sat_count  (sat_results)
    );

    // Result side: random stalls, steady acceptance, or a counted hold-off.
    // The hold-off runs once per entry into RX_HOLD, then ready stays high.
    always @(posedge i_clk) begin
        if (rx_mode == RX_HOLD && held_cycles < HOLD_CYCLES) begin
            i_out_ready <= 1'b0;
            held_cycles <= held_cycles + 1;
        end else begin
            if (rx_mode != RX_HOLD) held_cycles <= 0;
            i_out_ready <= (rx_mode != RX_RANDOM) || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Mostly full-range random, with the extremes and zero weighted in.
    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return '0;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic t_in_item acc_item(input logic [BIN_W-1:0] bin);
        t_in_item it;
        it.op         = OP_ACC;
        it.bin        = bin;
        it.descending = 1'($urandom_range(0, 1));
        it.bra_re     = pick_value();
        it.bra_im     = pick_value();
        it.ket_re     = pick_value();
        it.ket_im     = pick_value();
        it.dbra_re    = pick_value();
        it.dbra_im    = pick_value();
        it.dket_re    = pick_value();
        it.dket_im    = pick_value();
        return it;
    endfunction

    // Reads carry random junk in the fields they ignore.
    function automatic t_in_item read_item(input logic [BIN_W-1:0] bin);
        t_in_item it;
        it    = acc_item(bin);
        it.op = OP_READ;
        return it;
    endfunction

    // Every value field set to one value.
    function automatic t_in_item flat_item(
        input t_op                     op,
        input logic [BIN_W-1:0]        bin,
        input logic                    desc,
        input logic signed [VAL_W-1:0] v
    );
        t_in_item it;
        it            = {op, bin, desc, {8{v}}};
        return it;
    endfunction

    // One transaction on the input channel; idles first at random.
    task automatic send_item(input t_in_item it);
        while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // The checker books the last accepted read at the same edge, so look
    // at the count only from the next edge on.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (reads_outstanding != 0) @(posedge i_clk);
    endtask

    task automatic run_directed();
        t_in_item it;
        send_item(read_item('0));                          // never touched: zeros
        send_item(flat_item(OP_ACC, '0, 1'b1, VAL_MAX));
        send_item(flat_item(OP_ACC, '0, 1'b0, VAL_MIN));
        send_item(flat_item(OP_ACC, '0, 1'b1, VAL_MIN));
        send_item(read_item('0));
        send_item(read_item('0));                          // just cleared
        send_item(acc_item(BIN_W'(BINS - 1)));
        send_item(acc_item(BIN_W'(BINS - 1)));
        send_item(read_item(BIN_W'(BINS - 1)));
        // same values, both conjugation senses
        it            = acc_item(BIN_W'(2));
        it.descending = 1'b1;
        send_item(it);
        it.bin        = BIN_W'(3);
        it.descending = 1'b0;
        send_item(it);
        send_item(read_item(BIN_W'(2)));
        send_item(read_item(BIN_W'(3)));
        // hit the same bin back to back, then read/accumulate interleaved
        gaps_on = 1'b0;
        repeat (3) send_item(acc_item(BIN_W'(5)));
        send_item(read_item(BIN_W'(5)));
        send_item(acc_item(BIN_W'(5)));
        send_item(read_item(BIN_W'(5)));
        send_item(read_item(BIN_W'(5)));
        gaps_on = 1'b1;
    endtask

    // Bursts on a few hot bins, each closed by reading them all out,
    // with some noise on arbitrary bins and ops mixed in.
    task automatic run_bursts(input int n_items);
        logic [BIN_W-1:0] hot_bins [4];
        int               done;
        int               len;
        int               r;
        t_in_item         it;
        done = 0;
        while (done < n_items) begin
            foreach (hot_bins[s]) begin
                case ($urandom_range(0, 7))
                    0:       hot_bins[s] = '0;
                    1:       hot_bins[s] = BIN_W'(BINS - 1);
                    default: hot_bins[s] = BIN_W'($urandom_range(0, BINS - 1));
                endcase
            end
            len = $urandom_range(6, 16);
            repeat (len) begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    send_item(acc_item(hot_bins[$urandom_range(0, 3)]));
                end else if (r < 85) begin
                    send_item(read_item(hot_bins[$urandom_range(0, 3)]));
                end else begin
                    it    = acc_item(BIN_W'($urandom));
                    it.op = t_op'($urandom_range(0, 1));
                    send_item(it);
                end
            end
            foreach (hot_bins[s]) send_item(read_item(hot_bins[s]));
            done += len + 4;
        end
    endtask

    // Two bins hammered with extreme values: the first grows toward the
    // +,+,+,- limits, the second toward all four negative limits.
    task automatic run_saturation();
        t_in_item up_hit;
        t_in_item down_hit;
        up_hit   = {OP_ACC, BIN_W'(512), 1'b1, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MIN,
                    VAL_MIN, VAL_MIN, VAL_MAX, VAL_MIN};
        down_hit = {OP_ACC, BIN_W'(513), 1'b0, VAL_MIN, VAL_MIN, VAL_MAX, VAL_MIN,
                    VAL_MIN, VAL_MIN, VAL_MIN, VAL_MAX};
        // earlier random traffic may have left something in these bins
        send_item(read_item(up_hit.bin));
        send_item(read_item(down_hit.bin));
        repeat (SAT_HITS) begin
            send_item(up_hit);
            send_item(down_hit);
        end
        send_item(read_item(up_hit.bin));
        // ordinary terms on top of a large sum
        repeat (3) send_item(acc_item(down_hit.bin));
        send_item(read_item(down_hit.bin));
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // the block clears its RAM after reset; send_item waits it out
        run_directed();
        run_bursts(100);

        // back the block up: no result taken for a long stretch while
        // reads keep coming, so the input side has to stall
        gaps_on = 1'b0;
        rx_mode <= RX_HOLD;
        repeat (HOLD_READS) send_item(read_item(BIN_W'($urandom_range(0, BINS - 1))));
        rx_mode <= RX_RANDOM;
        gaps_on = 1'b1;

        // pause until every result is out, then resume
        wait_drained();
        run_bursts(80);

        // full rate on both sides
        gaps_on = 1'b0;
        rx_mode <= RX_STEADY;
        run_bursts(80);
        gaps_on = 1'b1;
        rx_mode <= RX_RANDOM;
        run_bursts(80);

        run_saturation();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d accumulate and %0d read transactions (%0d at a clamp),",
                 acc_count, read_count, sat_results);
        $display("a %0d-cycle output hold-off, a full-rate stretch and a drain pause.",
                 HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #LIMIT_NS;
        $display("Timeout with %0d reads outstanding", reads_outstanding);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
